// File: src/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants of the Euclidean signed divider.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int unsigned WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_e;

endpackage

// File: src/esd_step.sv
// ----------------------------------------------------------------------------
// esd_step
// One restoring division step: shift in a dividend bit, trial subtract the
// divisor magnitude, keep or restore the partial remainder.
// ----------------------------------------------------------------------------
module esd_step #(
  parameter int unsigned Width = esd_pkg::WIDTH_DEFAULT
) (
  input  logic [Width-1:0] rem_i,
  input  logic             msb_i,
  input  logic [Width-1:0] divisor_i,
  output logic [Width-1:0] rem_o,
  output logic             bit_o
);

  logic [Width:0] shifted;
  logic [Width:0] diff;

  assign shifted = {rem_i, msb_i};
  assign diff    = shifted - {1'b0, divisor_i};
  assign bit_o   = ~diff[Width];
  assign rem_o   = bit_o ? diff[Width-1:0] : shifted[Width-1:0];

endmodule

// File: src/euclidean_signed_divider_top.sv
// ----------------------------------------------------------------------------
// euclidean_signed_divider_top
// Euclidean signed divider: quotient with nonnegative remainder, zero flag,
// saturation of the most negative value divided by minus one.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, dividend_i,       | sink
//          | divisor_i                                 |
//  out     | out_valid_o, out_ready_i, quotient_o,     | source
//          | divide_by_zero_o                          |
//
//  An item runs one restoring step per quotient bit through the single
//  shared subtractor, then a sign fixup; a new item is taken only in idle.
//  A zero divisor skips the steps and goes straight to the fixup.
//  Reset clears the sequencer and the output valid; no clearing pass.
//  A stalled output word holds in the output register; the fixup waits for it.
// ----------------------------------------------------------------------------
module euclidean_signed_divider_top #(
  parameter int unsigned Width = esd_pkg::WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [Width-1:0] dividend_i,
  input  logic signed [Width-1:0] divisor_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [Width-1:0] quotient_o,
  output logic                    divide_by_zero_o
);

  localparam int unsigned CntW = $clog2(Width);
  localparam logic [Width-1:0] MaxPos = {1'b0, {(Width-1){1'b1}}};

  esd_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] mb_q, mb_d;
  logic             a_neg_q, a_neg_d;
  logic             b_neg_q, b_neg_d;
  logic             dbz_q, dbz_d;
  logic             out_valid_q, out_valid_d;
  logic [Width-1:0] quotient_q, quotient_d;
  logic             dbz_out_q, dbz_out_d;

  logic [Width-1:0] step_rem;
  logic             step_bit;
  logic             accept;
  logic             load_out;
  logic             inc;
  logic [Width:0]   pos_sum;
  logic [Width-1:0] fix_val;

  esd_step #(
    .Width(Width)
  ) u_step (
    .rem_i    (rem_q),
    .msb_i    (quo_q[Width-1]),
    .divisor_i(mb_q),
    .rem_o    (step_rem),
    .bit_o    (step_bit)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == esd_pkg::ST_FIX) && (!out_valid_q || out_ready_i);
  assign inc      = a_neg_q && (rem_q != '0);
  assign pos_sum  = {1'b0, quo_q} + {{Width{1'b0}}, inc};

  always_comb begin
    if (dbz_q) begin
      fix_val = '0;
    end else if (a_neg_q == b_neg_q) begin
      fix_val = (pos_sum > {1'b0, MaxPos}) ? MaxPos : pos_sum[Width-1:0];
    end else if (inc) begin
      fix_val = ~quo_q;
    end else begin
      fix_val = ~quo_q + {{(Width-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    mb_d        = mb_q;
    a_neg_d     = a_neg_q;
    b_neg_d     = b_neg_q;
    dbz_d       = dbz_q;
    out_valid_d = out_valid_q && !out_ready_i;
    quotient_d  = quotient_q;
    dbz_out_d   = dbz_out_q;
    in_ready_o  = 1'b0;
    case (state_q)
      esd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_neg_d = dividend_i[Width-1];
          b_neg_d = divisor_i[Width-1];
          quo_d   = dividend_i[Width-1] ? (~dividend_i + 1'b1) : dividend_i;
          mb_d    = divisor_i[Width-1] ? (~divisor_i + 1'b1) : divisor_i;
          rem_d   = '0;
          cnt_d   = CntW'(Width - 1);
          dbz_d   = (divisor_i == '0);
          state_d = (divisor_i == '0) ? esd_pkg::ST_FIX : esd_pkg::ST_RUN;
        end
      end
      esd_pkg::ST_RUN: begin
        rem_d = step_rem;
        quo_d = {quo_q[Width-2:0], step_bit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = esd_pkg::ST_FIX;
        end
      end
      esd_pkg::ST_FIX: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          quotient_d  = fix_val;
          dbz_out_d   = dbz_q;
          state_d     = esd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = esd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    mb_q       <= mb_d;
    a_neg_q    <= a_neg_d;
    b_neg_q    <= b_neg_d;
    dbz_q      <= dbz_d;
    quotient_q <= quotient_d;
    dbz_out_q  <= dbz_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = quotient_q;
  assign divide_by_zero_o = dbz_out_q;

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> quotient_o == '0)
    else $error("divide by zero word carries a nonzero quotient");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == esd_pkg::ST_RUN || state_q == esd_pkg::ST_FIX))
    else $error("accepted word did not start the sequencer");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == esd_pkg::ST_RUN |-> rem_q < mb_q)
    else $error("partial remainder reached the divisor magnitude");

endmodule
